FILE: rtl/spq_pkg.sv
`default_nettype none
package spq_pkg;

    localparam int NODES    = 256;
    localparam int NODE_W   = 8;
    localparam int EDGES    = 1024;
    localparam int EDGE_AW  = 10;
    localparam int LINK_W   = EDGE_AW + 1;
    localparam int WGT_W    = 16;
    localparam int DIST_W   = 24;
    localparam int SCAN_W   = NODE_W + 1;
    localparam int EDGE_DW  = NODE_W + WGT_W + LINK_W;

    // A link with the top bit set marks the end of a node's edge list.
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(EDGES);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_PICK,
        S_HEAD,
        S_EDGE,
        S_DIST,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]        operation;
        logic [NODE_W-1:0] edge_from;
        logic [NODE_W-1:0] edge_to;
        logic [WGT_W-1:0]  edge_weight;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] target_node;
    } t_in;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              reachable;
        logic              edges_dropped;
    } t_out;

endpackage
`default_nettype wire

FILE: rtl/spq_if.sv
`default_nettype none
interface spq_in_if import spq_pkg::*;;
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spq_out_if import spq_pkg::*;;
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/spq_ram.sv
`default_nettype none
module spq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/shortest_path_query_core.sv
// Clear items are done in the idle state; edge items do a head-of-list read, then the writes.
// A query goes straight to the finish state when source equals target; otherwise it
// repeats a scan, a pick of the nearest unsettled node and the relaxing of its edges:
// each selection scans all 256 distance entries through one memory read port.
// A finished result waits in an output register; edge and clear items are still taken.
// Reset clears the graph (all lists empty, edge count and drop flag zero) at once.
`default_nettype none
module shortest_path_query_core import spq_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    spq_in_if.sink      i_in,
    spq_out_if.source   o_out
);

    // Control state.
    t_state               r_state, n_state;
    logic [SCAN_W-1:0]    r_cnt;
    logic [LINK_W-1:0]    r_total;
    logic                 r_ovf;
    logic [NODES-1:0]     r_head_vld;
    logic                 r_out_vld;

    // Per-query node flags: a tentative distance exists, the node is settled.
    logic [NODES-1:0]     r_known;
    logic [NODES-1:0]     r_visited;

    // Datapath registers.
    logic [NODE_W-1:0]    r_from, r_eto, r_tgt, r_rd_idx, r_best_idx, r_to;
    logic [WGT_W-1:0]     r_ew;
    logic                 r_best_vld;
    logic [DIST_W-1:0]    r_best_dist, r_udist, r_nd, r_fin_dist;
    logic [LINK_W-1:0]    r_link;
    logic                 r_fin_reach;
    t_out                 r_out;

    // Memory ports.
    logic                 head_we;
    logic [NODE_W-1:0]    head_raddr;
    logic [EDGE_AW-1:0]   head_q;
    logic                 edge_we;
    logic [EDGE_AW-1:0]   edge_raddr;
    logic [EDGE_DW-1:0]   edge_wdata, edge_q;
    logic                 dist_we;
    logic [NODE_W-1:0]    dist_waddr, dist_raddr;
    logic [DIST_W-1:0]    dist_wdata, dist_q;

    logic [NODE_W-1:0]    eq_to;
    logic [WGT_W-1:0]     eq_w;
    logic [LINK_W-1:0]    eq_link;
    logic                 in_acc;
    logic                 scan_take;
    logic                 relax;
    logic                 fin_go;

    assign {eq_to, eq_w, eq_link} = edge_q;
    assign in_acc = i_in.valid && i_in.ready;

    // The head of each node's edge list; valid bits stand for the empty reset state.
    spq_ram #(.DEPTH(NODES), .WIDTH(EDGE_AW)) u_head (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (r_from),
        .i_wdata (r_total[EDGE_AW-1:0]),
        .i_raddr (head_raddr),
        .o_rdata (head_q)
    );

    // Edge records: end node, weight and link to the next edge of the same start node.
    spq_ram #(.DEPTH(EDGES), .WIDTH(EDGE_DW)) u_edge (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (r_total[EDGE_AW-1:0]),
        .i_wdata (edge_wdata),
        .i_raddr (edge_raddr),
        .o_rdata (edge_q)
    );

    // Tentative distance of each node; r_known marks the entries that are meaningful.
    spq_ram #(.DEPTH(NODES), .WIDTH(DIST_W)) u_dist (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (dist_raddr),
        .o_rdata (dist_q)
    );

    // A scanned entry becomes the best candidate when it is known, unsettled and smaller.
    assign scan_take = (r_cnt != '0) && r_known[r_rd_idx] && !r_visited[r_rd_idx] &&
                       (!r_best_vld || (dist_q < r_best_dist));

    // A relaxed edge improves its end node when that node has no distance yet or a larger one.
    assign relax  = !r_known[r_to] || (r_nd < dist_q);
    assign fin_go = !r_out_vld || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.data.operation == OP_ADD) begin
                        n_state = S_ADD;
                    end else if (i_in.data.operation == OP_QUERY) begin
                        n_state = (i_in.data.source_node == i_in.data.target_node) ?
                                  S_FIN : S_SCAN;
                    end
                end
            end
            S_ADD:  n_state = S_IDLE;
            S_SCAN: begin
                if (r_cnt == SCAN_W'(NODES)) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (!r_best_vld || (r_best_idx == r_tgt)) begin
                    n_state = S_FIN;
                end else if (r_head_vld[r_best_idx]) begin
                    n_state = S_HEAD;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_HEAD: n_state = S_EDGE;
            S_EDGE: n_state = S_DIST;
            S_DIST: n_state = r_link[LINK_W-1] ? S_SCAN : S_EDGE;
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        head_we    = (r_state == S_ADD) && !r_total[LINK_W-1];
        edge_we    = head_we;
        head_raddr = (r_state == S_PICK) ? r_best_idx : i_in.data.edge_from;
        edge_wdata = {r_eto, r_ew, r_head_vld[r_from] ? {1'b0, head_q} : LINK_NULL};
        edge_raddr = (r_state == S_HEAD) ? head_q : r_link[EDGE_AW-1:0];
        dist_we    = (r_state == S_IDLE) ? (in_acc && (i_in.data.operation == OP_QUERY))
                                         : ((r_state == S_DIST) && relax);
        dist_waddr = (r_state == S_IDLE) ? i_in.data.source_node : r_to;
        dist_wdata = (r_state == S_IDLE) ? '0 : r_nd;
        dist_raddr = (r_state == S_EDGE) ? eq_to : r_cnt[NODE_W-1:0];
        o_out.valid = r_out_vld;
        o_out.data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_total    <= '0;
            r_ovf      <= 1'b0;
            r_head_vld <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_FIN) && fin_go) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if ((r_state == S_IDLE) && in_acc && (i_in.data.operation == OP_CLEAR)) begin
                r_total    <= '0;
                r_ovf      <= 1'b0;
                r_head_vld <= '0;
            end
            if (r_state == S_ADD) begin
                if (r_total[LINK_W-1]) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_head_vld[r_from] <= 1'b1;
                    r_total            <= r_total + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_from      <= i_in.data.edge_from;
                r_eto       <= i_in.data.edge_to;
                r_ew        <= i_in.data.edge_weight;
                r_tgt       <= i_in.data.target_node;
                r_cnt       <= '0;
                r_best_vld  <= 1'b0;
                r_known     <= {{(NODES-1){1'b0}}, 1'b1} << i_in.data.source_node;
                r_visited   <= '0;
                r_fin_dist  <= '0;
                r_fin_reach <= 1'b1;
            end
            S_SCAN: begin
                r_cnt    <= r_cnt + 1'b1;
                r_rd_idx <= r_cnt[NODE_W-1:0];
                if (scan_take) begin
                    r_best_vld  <= 1'b1;
                    r_best_idx  <= r_rd_idx;
                    r_best_dist <= dist_q;
                end
            end
            S_PICK: begin
                r_fin_dist  <= r_best_vld ? r_best_dist : '0;
                r_fin_reach <= r_best_vld;
                r_udist     <= r_best_dist;
                r_visited[r_best_idx] <= 1'b1;
                r_cnt       <= '0;
                r_best_vld  <= 1'b0;
            end
            S_EDGE: begin
                r_to   <= eq_to;
                r_nd   <= r_udist + DIST_W'(eq_w);
                r_link <= eq_link;
            end
            S_DIST: begin
                if (relax) begin
                    r_known[r_to] <= 1'b1;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    r_out.distance      <= r_fin_dist;
                    r_out.reachable     <= r_fin_reach;
                    r_out.edges_dropped <= r_ovf;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/spq_checker.sv
`default_nettype none
module spq_checker import spq_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic [1:0]        i_in_op,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [DIST_W-1:0] i_out_distance,
    input wire logic              i_out_reachable
);

    // A result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    // An unreachable target reports a zero distance.
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_reachable |-> (i_out_distance == '0))
        else $error("unreachable result with nonzero distance");

    // An accepted query keeps the input closed in the following cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_op == OP_QUERY) |=> !i_in_ready)
        else $error("input open right after a query was accepted");

    // A new result appears only at the end of a search, while the input is closed.
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a search");

endmodule

bind shortest_path_query_core spq_checker u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_op         (i_in.data.operation),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_distance  (o_out.data.distance),
    .i_out_reachable (o_out.data.reachable)
);
`default_nettype wire
